FILE: hdl/hts_pkg.sv
`default_nettype none
package hts_pkg;

  localparam int CODE_BITS = 64;
  localparam int MAX_K     = 16;

  localparam int DIST_W  = 7;
  localparam int ID_W    = 64;
  localparam int VID_W   = 63;
  localparam int LIST_W  = 31;
  localparam int OFS_W   = 32;
  localparam int CNT_W   = 16;
  localparam int TOPK_W  = 5;
  localparam int K_W     = $clog2(MAX_K + 1);
  localparam int NCHUNK  = (CODE_BITS + 7) / 8;

  localparam logic [DIST_W-1:0] EMPTY_DIST = DIST_W'(65);
  localparam logic [ID_W-1:0]   EMPTY_ID   = '1;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_QUERY_CODE  = 3'd0,
    REG_SEARCH_MODE = 3'd1,
    REG_TOP_K       = 3'd2,
    REG_RADIUS      = 3'd3,
    REG_PAIR_IDS    = 3'd4,
    REG_LIST_NUMBER = 3'd5
  } hts_reg_t;

  typedef struct packed {
    logic [63:0]         query_code;
    logic                search_mode;
    logic [TOPK_W-1:0]   top_k;
    logic [DIST_W-1:0]   radius;
    logic                pair_ids;
    logic [LIST_W-1:0]   list_number;
  } hts_cfg_t;

  // front stage: per-byte bit counts still to be summed
  typedef struct packed {
    logic [NCHUNK-1:0][3:0] cnt;
    logic [ID_W-1:0]        id;
    logic                   eoq;
  } hts_stage_t;

  // one classified code waiting for the list
  typedef struct packed {
    logic [DIST_W-1:0] hdist;
    logic [ID_W-1:0]   id;
    logic              eoq;
  } hts_item_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hamming_topk_code_scanner.sv
// range mode: a code passes the front stage register and the queue; its result leaves on out_tvalid
// top-k mode: the end-of-query code drains the list as k beats, one per cycle when taken
// throughput: one code per cycle unless out_tready stalls, set by the back end's sorted insertion;
//   an end-of-query code in top-k mode holds the back end while the list drains
// reset: synchronous active-low; config returns to defaults (top_k 16), list empty,
//   list offset and admission count zero, no clearing pass
`default_nettype none
module hamming_topk_code_scanner (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // code stream
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,   // code[63:0], vector_id[126:64], zero pad [127]
  input  wire logic          in_tlast,   // end_of_query
  input  wire logic          in_tuser,   // last_of_list
  // result stream
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [87:0]        out_tdata,  // result_distance[6:0], result_id[70:7],
                                         // update_count[86:71], zero pad [87]
  output logic               out_tlast,  // last_result
  // register writes
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [63:0]   cfg_wdata
);

  hts_pkg::hts_cfg_t               cfg_r, cfg_nxt;
  logic                            push_valid, push_ready;
  hts_pkg::hts_item_t              push_item;
  logic                            q_valid, q_pop;
  hts_pkg::hts_item_t              q_item;
  logic [hts_pkg::DIST_W-1:0]      result_distance;
  logic [hts_pkg::ID_W-1:0]        result_id;
  logic [hts_pkg::CNT_W-1:0]       update_count;
  logic                            last_result;

  // register file; the user must write it only while the block is idle, the block does not enforce this
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (hts_pkg::hts_reg_t'(cfg_addr))
        hts_pkg::REG_QUERY_CODE:  cfg_nxt.query_code  = cfg_wdata;
        hts_pkg::REG_SEARCH_MODE: cfg_nxt.search_mode = cfg_wdata[0];
        hts_pkg::REG_TOP_K:       cfg_nxt.top_k       = cfg_wdata[hts_pkg::TOPK_W-1:0];
        hts_pkg::REG_RADIUS:      cfg_nxt.radius      = cfg_wdata[hts_pkg::DIST_W-1:0];
        hts_pkg::REG_PAIR_IDS:    cfg_nxt.pair_ids    = cfg_wdata[0];
        hts_pkg::REG_LIST_NUMBER: cfg_nxt.list_number = cfg_wdata[hts_pkg::LIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_code  <= '0;
      cfg_r.search_mode <= 1'b0;
      cfg_r.top_k       <= hts_pkg::TOPK_W'(16);
      cfg_r.radius      <= '0;
      cfg_r.pair_ids    <= 1'b0;
      cfg_r.list_number <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: distance by byte counts, id selection, list offset
  hts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .code         (in_tdata[63:0]),
    .vector_id    (in_tdata[126:64]),
    .last_of_list (in_tuser),
    .end_of_query (in_tlast),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // two-entry queue decouples front and list
  hts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // back: sorted k-list, range check, result register
  hts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .result_distance (result_distance),
    .result_id       (result_id),
    .update_count    (update_count),
    .last_result     (last_result)
  );

  assign out_tdata = {1'b0, update_count, result_id, result_distance};
  assign out_tlast = last_result;

endmodule
`default_nettype wire

FILE: hdl/hts_front.sv
`default_nettype none
module hts_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire hts_pkg::hts_cfg_t               cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [63:0]                     code,
  input  wire logic [hts_pkg::VID_W-1:0]       vector_id,
  input  wire logic                            last_of_list,
  input  wire logic                            end_of_query,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output hts_pkg::hts_item_t                   push_item
);

  logic                           stg_valid_r, stg_valid_nxt;
  hts_pkg::hts_stage_t            stg_r, stg_nxt;
  logic [hts_pkg::OFS_W-1:0]      offset_r, offset_nxt;
  logic [hts_pkg::NCHUNK*8-1:0]   diff;
  logic                           accept;
  logic [hts_pkg::DIST_W-1:0]     dist_sum;

  assign in_ready   = !stg_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = stg_valid_r;

  assign diff = (hts_pkg::NCHUNK*8)'(code[hts_pkg::CODE_BITS-1:0] ^
                                     cfg.query_code[hts_pkg::CODE_BITS-1:0]);

  always_comb begin
    dist_sum = '0;
    for (int c = 0; c < hts_pkg::NCHUNK; c++) begin
      dist_sum = dist_sum + hts_pkg::DIST_W'(stg_r.cnt[c]);
    end
  end

  assign push_item.hdist = dist_sum;
  assign push_item.id    = stg_r.id;
  assign push_item.eoq   = stg_r.eoq;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_nxt       = stg_r;
    offset_nxt    = offset_r;
    if (stg_valid_r && push_ready) begin
      stg_valid_nxt = 1'b0;
    end
    if (accept) begin
      stg_valid_nxt = 1'b1;
      for (int c = 0; c < hts_pkg::NCHUNK; c++) begin
        stg_nxt.cnt[c] = hts_pkg::popcount8(diff[c*8 +: 8]);
      end
      if (cfg.pair_ids) begin
        stg_nxt.id = {1'b0, cfg.list_number, offset_r};
      end else begin
        stg_nxt.id = {1'b0, vector_id};
      end
      stg_nxt.eoq = end_of_query;
      offset_nxt  = last_of_list ? '0 : offset_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      offset_r    <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      offset_r    <= offset_nxt;
    end
    stg_r <= stg_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/hts_queue.sv
`default_nettype none
module hts_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire hts_pkg::hts_item_t push_item,
  output logic                    pop_valid,
  input  wire logic               pop,
  output hts_pkg::hts_item_t      pop_item
);

  hts_pkg::hts_item_t ent_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hts_back.sv
`default_nettype none
module hts_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hts_pkg::hts_cfg_t           cfg,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  input  wire hts_pkg::hts_item_t          q_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hts_pkg::DIST_W-1:0]       result_distance,
  output logic [hts_pkg::ID_W-1:0]         result_id,
  output logic [hts_pkg::CNT_W-1:0]        update_count,
  output logic                             last_result
);

  typedef enum logic {ST_RUN, ST_EMIT} state_t;

  state_t                       state_r, state_nxt;
  logic [hts_pkg::DIST_W-1:0]   best_d_r   [hts_pkg::MAX_K];
  logic [hts_pkg::DIST_W-1:0]   best_d_nxt [hts_pkg::MAX_K];
  logic [hts_pkg::ID_W-1:0]     best_id_r  [hts_pkg::MAX_K];
  logic [hts_pkg::ID_W-1:0]     best_id_nxt[hts_pkg::MAX_K];
  logic [hts_pkg::DIST_W-1:0]   sh_d       [hts_pkg::MAX_K];
  logic [hts_pkg::ID_W-1:0]     sh_id      [hts_pkg::MAX_K];
  logic [hts_pkg::CNT_W-1:0]    adm_r, adm_nxt;
  logic [hts_pkg::K_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hts_pkg::DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [hts_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [hts_pkg::CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [hts_pkg::K_W-1:0]      keff;
  logic [hts_pkg::DIST_W-1:0]   kth_d;
  logic [hts_pkg::MAX_K:0]      le_ext;
  logic                         admit;
  logic                         out_free;
  logic                         emit_last;

  assign out_valid       = out_valid_r;
  assign result_distance = out_dist_r;
  assign result_id       = out_id_r;
  assign update_count    = out_cnt_r;
  assign last_result     = out_last_r;
  assign out_free        = !out_valid_r || out_ready;

  // clamp k into 1..MAX_K
  always_comb begin
    if (cfg.top_k == '0) begin
      keff = hts_pkg::K_W'(1);
    end else if (32'(cfg.top_k) > hts_pkg::MAX_K) begin
      keff = hts_pkg::K_W'(hts_pkg::MAX_K);
    end else begin
      keff = hts_pkg::K_W'(cfg.top_k);
    end
  end

  assign emit_last = (emit_cnt_r == keff - hts_pkg::K_W'(1));

  // slot compares; le_ext[i+1] means slot i stays ahead of the new code
  always_comb begin
    kth_d     = hts_pkg::EMPTY_DIST;
    le_ext[0] = 1'b1;
    for (int i = 0; i < hts_pkg::MAX_K; i++) begin
      le_ext[i+1] = (best_d_r[i] <= q_item.hdist);
      if (32'(i) == 32'(keff) - 1) begin
        kth_d = best_d_r[i];
      end
    end
    sh_d[0]  = hts_pkg::EMPTY_DIST;
    sh_id[0] = hts_pkg::EMPTY_ID;
    for (int i = 1; i < hts_pkg::MAX_K; i++) begin
      sh_d[i]  = best_d_r[i-1];
      sh_id[i] = best_id_r[i-1];
    end
  end

  assign admit = (q_item.hdist < kth_d);

  always_comb begin
    state_nxt     = state_r;
    best_d_nxt    = best_d_r;
    best_id_nxt   = best_id_r;
    adm_nxt       = adm_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dist_nxt  = out_dist_r;
    out_id_nxt    = out_id_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (!cfg.search_mode) begin
            if (admit) begin
              for (int i = 0; i < hts_pkg::MAX_K; i++) begin
                if (32'(i) < 32'(keff) && !le_ext[i+1]) begin
                  if (le_ext[i]) begin
                    best_d_nxt[i]  = q_item.hdist;
                    best_id_nxt[i] = q_item.id;
                  end else begin
                    best_d_nxt[i]  = sh_d[i];
                    best_id_nxt[i] = sh_id[i];
                  end
                end
              end
              if (adm_r != '1) begin
                adm_nxt = adm_r + 1'b1;
              end
            end
            if (q_item.eoq) begin
              state_nxt    = ST_EMIT;
              emit_cnt_nxt = '0;
            end
          end else begin
            if (q_item.hdist < cfg.radius) begin
              out_valid_nxt = 1'b1;
              out_dist_nxt  = q_item.hdist;
              out_id_nxt    = q_item.id;
              out_cnt_nxt   = adm_r;
              out_last_nxt  = 1'b1;
            end
            if (q_item.eoq) begin
              for (int i = 0; i < hts_pkg::MAX_K; i++) begin
                best_d_nxt[i]  = hts_pkg::EMPTY_DIST;
                best_id_nxt[i] = hts_pkg::EMPTY_ID;
              end
              adm_nxt = '0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = best_d_r[0];
          out_id_nxt    = best_id_r[0];
          out_cnt_nxt   = adm_r;
          out_last_nxt  = emit_last;
          emit_cnt_nxt  = emit_cnt_r + 1'b1;
          // list drains from the head
          for (int i = 0; i < hts_pkg::MAX_K - 1; i++) begin
            best_d_nxt[i]  = best_d_r[i+1];
            best_id_nxt[i] = best_id_r[i+1];
          end
          best_d_nxt[hts_pkg::MAX_K-1]  = hts_pkg::EMPTY_DIST;
          best_id_nxt[hts_pkg::MAX_K-1] = hts_pkg::EMPTY_ID;
          if (emit_last) begin
            for (int i = 0; i < hts_pkg::MAX_K; i++) begin
              best_d_nxt[i]  = hts_pkg::EMPTY_DIST;
              best_id_nxt[i] = hts_pkg::EMPTY_ID;
            end
            adm_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      adm_r       <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < hts_pkg::MAX_K; i++) begin
        best_d_r[i]  <= hts_pkg::EMPTY_DIST;
        best_id_r[i] <= hts_pkg::EMPTY_ID;
      end
    end else begin
      state_r     <= state_nxt;
      adm_r       <= adm_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      best_d_r    <= best_d_nxt;
      best_id_r   <= best_id_nxt;
    end
    out_dist_r <= out_dist_nxt;
    out_id_r   <= out_id_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTH
  a_sorted_ends: assert property (@(posedge clk) disable iff (!rst_n)
    best_d_r[0] <= best_d_r[hts_pkg::MAX_K-1])
    else $error("list head beyond list tail");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> 32'(emit_cnt_r) < 32'(keff))
    else $error("emit count past k");

  a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !q_pop)
    else $error("queue popped while draining list");

  a_range_no_admit: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && cfg.search_mode && !q_item.eoq) |=> $stable(adm_r))
    else $error("range mode changed admissions");
`endif

endmodule
`default_nettype wire
